[rtl/rse_pkg.sv]
package rse_pkg;

	// Fixed field widths
	localparam int DATA_W      = 32;
	localparam int CMD_W       = 3;
	localparam int STATUS_W    = 3;
	localparam int DEPTH_OUT_W = 5;

	// Defaults for the top-level parameters
	localparam int DEF_STACK_DEPTH   = 16;
	localparam int DEF_FRACTION_BITS = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 3'd0,
		CMD_ADD    = 3'd1,
		CMD_SUB    = 3'd2,
		CMD_MUL    = 3'd3,
		CMD_FINISH = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_TOTAL       = 3'd1,
		ST_NONE        = 3'd2,
		ST_OVERFLOW    = 3'd3,
		ST_FEW         = 3'd4,
		ST_UNSUPPORTED = 3'd5,
		ST_HALTED      = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD2,
		S_EXEC,
		S_WB,
		S_POP
	} state_t;

endpackage

[rtl/rpn_stack_evaluator.sv]
// Channel  | Signals                                  | Handshake
// ---------+------------------------------------------+-------------------------------
// command  | command, operand_value                   | taken when start && !busy
// result   | status, result_value, stack_depth        | valid one cycle while done
//
// Push, errors, refused and empty-finish words: result in the cycle after accept,
// busy stays low. Finish with entries passes through S_POP (one stack read).
// Add/sub/mul: two reads of the stack RAM (one read port), one pass
// through the shared ALU (add, subtract or 32x32 multiply), then shift,
// saturate and write back in S_WB. busy is high in S_RD2, S_EXEC and S_WB.
// Reset clears the depth counter, halt flag and sequencer; stack RAM is not
// cleared. The receiver cannot stall; each result shows for one cycle only.
module rpn_stack_evaluator #(
	parameter int STACK_DEPTH   = rse_pkg::DEF_STACK_DEPTH,
	parameter int FRACTION_BITS = rse_pkg::DEF_FRACTION_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic        [rse_pkg::CMD_W-1:0]        command,
	input  logic signed [rse_pkg::DATA_W-1:0]       operand_value,
	output logic                                    busy,
	output logic                                    done,
	output logic        [rse_pkg::STATUS_W-1:0]     status,
	output logic signed [rse_pkg::DATA_W-1:0]       result_value,
	output logic        [rse_pkg::DEPTH_OUT_W-1:0]  stack_depth
);
	import rse_pkg::*;

	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int DW    = $clog2(STACK_DEPTH + 1);
	localparam int WIDE  = 2 * DATA_W;

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	state_t state_q, nxt_state;

	logic [DW-1:0] depth_q;
	logic          halted_q;
	cmd_t          cmd_q;
	logic          done_q;
	status_t       status_q;
	logic signed [DATA_W-1:0] result_q;

	logic signed [DATA_W-1:0] mem [STACK_DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;
	logic signed [DATA_W-1:0] a_q;
	logic signed [WIDE-1:0]   alu_q;

	// sequencer controls
	logic          accept;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic signed [DATA_W-1:0] mem_wdata;
	logic [AW-1:0] rd_addr;
	logic          depth_inc, depth_dec, halt_set, done_set;
	status_t       status_d;
	logic signed [DATA_W-1:0] result_d;

	// shared ALU and saturation
	logic signed [WIDE-1:0]   alu_d;
	logic signed [WIDE-1:0]   shifted;
	logic signed [DATA_W-1:0] sat_val;
	logic [DW+DEPTH_OUT_W-1:0] depth_ext;

	assign accept = start && !busy;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= nxt_state;
		end
	end

	// Next state and controls
	always_comb begin
		nxt_state = state_q;
		mem_we    = 1'b0;
		mem_waddr = depth_q[AW-1:0];
		mem_wdata = operand_value;
		rd_addr   = AW'(depth_q - DW'(1));
		depth_inc = 1'b0;
		depth_dec = 1'b0;
		halt_set  = 1'b0;
		done_set  = 1'b0;
		status_d  = ST_OK;
		result_d  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (halted_q) begin
						done_set = 1'b1;
						status_d = ST_HALTED;
					end else begin
						unique case (command)
							CMD_PUSH: begin
								done_set = 1'b1;
								if (depth_q >= DW'(STACK_DEPTH)) begin
									status_d = ST_OVERFLOW;
									halt_set = 1'b1;
								end else begin
									mem_we    = 1'b1;
									depth_inc = 1'b1;
									result_d  = operand_value;
								end
							end
							CMD_ADD, CMD_SUB, CMD_MUL: begin
								if (depth_q < DW'(2)) begin
									done_set = 1'b1;
									status_d = ST_FEW;
									halt_set = 1'b1;
								end else begin
									nxt_state = S_RD2;
								end
							end
							CMD_FINISH: begin
								if (depth_q == '0) begin
									done_set = 1'b1;
									status_d = ST_NONE;
								end else begin
									nxt_state = S_POP;
								end
							end
							default: begin
								done_set = 1'b1;
								status_d = ST_UNSUPPORTED;
								halt_set = 1'b1;
							end
						endcase
					end
				end
			end
			S_RD2: begin
				rd_addr   = AW'(depth_q - DW'(2));
				nxt_state = S_EXEC;
			end
			S_EXEC: begin
				nxt_state = S_WB;
			end
			S_WB: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(depth_q - DW'(2));
				mem_wdata = sat_val;
				depth_dec = 1'b1;
				done_set  = 1'b1;
				result_d  = sat_val;
				nxt_state = S_IDLE;
			end
			S_POP: begin
				depth_dec = 1'b1;
				done_set  = 1'b1;
				status_d  = ST_TOTAL;
				result_d  = rd_data_q;
				nxt_state = S_IDLE;
			end
			default: begin
				nxt_state = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// Stack RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Shared ALU: second-from-top op top
	always_comb begin
		unique case (cmd_q)
			CMD_ADD: alu_d = WIDE'(rd_data_q) + WIDE'(a_q);
			CMD_SUB: alu_d = WIDE'(rd_data_q) - WIDE'(a_q);
			default: alu_d = rd_data_q * a_q;
		endcase
	end

	// Floor shift for products, then clamp to 32 bits
	always_comb begin
		shifted = (cmd_q == CMD_MUL) ? (alu_q >>> FRACTION_BITS) : alu_q;
		if (&shifted[WIDE-1:DATA_W-1] || ~|shifted[WIDE-1:DATA_W-1]) begin
			sat_val = shifted[DATA_W-1:0];
		end else begin
			sat_val = shifted[WIDE-1] ? SAT_MIN : SAT_MAX;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(command);
		end
		if (state_q == S_RD2) begin
			a_q <= rd_data_q;
		end
		if (state_q == S_EXEC) begin
			alu_q <= alu_d;
		end
		if (done_set) begin
			status_q <= status_d;
			result_q <= result_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			halted_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= done_set;
			if (halt_set) begin
				halted_q <= 1'b1;
			end
			if (depth_inc) begin
				depth_q <= depth_q + DW'(1);
			end else if (depth_dec) begin
				depth_q <= depth_q - DW'(1);
			end
		end
	end

	// Result ports; depth reported modulo 32
	assign depth_ext    = {{DEPTH_OUT_W{1'b0}}, depth_q};
	assign done         = done_q;
	assign status       = status_q;
	assign result_value = result_q;
	assign stack_depth  = depth_ext[DEPTH_OUT_W-1:0];

endmodule

[rtl/rse_checker.sv]
module rse_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    start,
	input logic                                    busy,
	input logic                                    done,
	input logic        [rse_pkg::STATUS_W-1:0]     status,
	input logic signed [rse_pkg::DATA_W-1:0]       result_value,
	input logic        [rse_pkg::DEPTH_OUT_W-1:0]  stack_depth
);
	import rse_pkg::*;

	// A result word always lands with the sequencer back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while busy");

	// Depth only moves together with a result word
	a_depth_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(stack_depth))
		else $error("stack depth changed without a result word");

	// Error and empty results carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK && status != ST_TOTAL |-> result_value == '0)
		else $error("nonzero value on error result");

	// Error and empty results leave the stack depth unchanged
	a_err_depth: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_OVERFLOW || status == ST_FEW ||
		status == ST_UNSUPPORTED || status == ST_HALTED || status == ST_NONE)
		|-> stack_depth == $past(stack_depth))
		else $error("stack depth moved on error result");

	// Entering a multi-cycle word never coincides with its result
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !done && $past(start))
		else $error("busy rose without an accepted word");

endmodule

bind rpn_stack_evaluator rse_checker u_rse_checker (.*);
